@@ rtl/core/frame_crc_conv_encoder_assert.svh @@
// ---------------------------------------------------------------------------
// assertion helpers for the frame crc convolutional encoder
// ---------------------------------------------------------------------------
`ifndef FRAME_CRC_CONV_ENCODER_ASSERT_SVH
`define FRAME_CRC_CONV_ENCODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FCCE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcce assertion failed");

// next-cycle implication, disabled in reset
`define FCCE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcce assertion failed");

`endif

@@ rtl/core/fcce_pkg.sv @@
// ---------------------------------------------------------------------------
// fcce_pkg
// types, constants and crc helpers of the frame crc convolutional encoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcce_pkg;

    localparam int FRAME_PAYLOAD_DEF = 64;
    localparam int CRC_W             = 8;
    localparam int PAD_BITS          = 8;
    localparam logic [CRC_W-1:0] CRC_POLY_RESET = 8'h07;
    localparam logic [CRC_W-1:0] CRC_TOP_BIT    = 8'h80;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // apb register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CRC_POLY = '0;

    typedef struct packed {
        logic data_bit;
        logic message_end;
    } in_beat_t;

    typedef struct packed {
        logic coded_first;
        logic coded_second;
        logic frame_end;
        logic run_last;
    } out_beat_t;

    // one classified input bit, as handed from front to back
    typedef struct packed {
        logic             data_bit;
        logic             closes;
        logic             pad;
        logic [CRC_W-1:0] crc;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD,
        PH_CRC
    } phase_t;

    function automatic logic [CRC_W-1:0] crc_step(
        input logic [CRC_W-1:0] crc,
        input logic             b,
        input logic [CRC_W-1:0] poly
    );
        logic [CRC_W-1:0] r;
        r = crc ^ (b ? CRC_TOP_BIT : '0);
        if ((r & CRC_TOP_BIT) != '0)
        begin
            return (r << 1) ^ poly;
        end
        return r << 1;
    endfunction

    // crc after the zero pad bits of a short frame
    function automatic logic [CRC_W-1:0] crc_pad(
        input logic [CRC_W-1:0] crc,
        input logic [CRC_W-1:0] poly
    );
        logic [CRC_W-1:0] r;
        r = crc;
        for (int i = 0; i < PAD_BITS; i++)
        begin
            r = crc_step(r, 1'b0, poly);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fcce_front.sv @@
// ---------------------------------------------------------------------------
// fcce_front
// takes message bits, runs the frame crc and marks frame closes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcce_front #(
    parameter int FRAME_PAYLOAD = fcce_pkg::FRAME_PAYLOAD_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [fcce_pkg::CRC_W-1:0] crc_poly,
    input  wire logic                       bit_valid,
    output logic                            bit_stall,
    input  wire fcce_pkg::in_beat_t         bit_data,
    input  wire fcce_pkg::queue_status_t    q_status,
    output logic                            push,
    output fcce_pkg::job_t                  push_job
);
    import fcce_pkg::*;

    localparam int CNT_W = (FRAME_PAYLOAD > 1) ? $clog2(FRAME_PAYLOAD) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_PAYLOAD - 1);

    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CRC_W-1:0] crc_bit;
    logic             fills;

    assign bit_stall = q_status.full;
    assign push      = bit_valid && !q_status.full;

    always_comb
    begin
        crc_bit = crc_step(crc_reg, bit_data.data_bit, crc_poly);
        fills   = (count_reg == CNT_LAST);

        push_job.data_bit = bit_data.data_bit;
        push_job.closes   = fills || bit_data.message_end;
        push_job.pad      = bit_data.message_end && !fills;
        push_job.crc      = push_job.pad ? crc_pad(crc_bit, crc_poly) : crc_bit;

        crc_next   = crc_reg;
        count_next = count_reg;
        if (push)
        begin
            if (push_job.closes)
            begin
                crc_next   = '0;
                count_next = '0;
            end
            else
            begin
                crc_next   = crc_bit;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fcce_queue.sv @@
// ---------------------------------------------------------------------------
// fcce_queue
// short fifo of classified bits between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcce_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire fcce_pkg::job_t          push_job,
    input  wire logic                    pop,
    output fcce_pkg::job_t               head,
    output fcce_pkg::queue_status_t      q_status
);
    import fcce_pkg::*;

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.empty = (fill_reg == '0);
    assign q_status.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fcce_back.sv @@
// ---------------------------------------------------------------------------
// fcce_back
// expands queued bits into pad and crc bits and runs the k=3 encoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcce_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire fcce_pkg::job_t          head,
    input  wire fcce_pkg::queue_status_t q_status,
    output logic                         pop,
    output logic                         pair_valid,
    input  wire logic                    pair_stall,
    output fcce_pkg::out_beat_t          pair_data
);
    import fcce_pkg::*;

    localparam int IDX_W = $clog2(PAD_BITS);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       hist_reg, hist_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_beat_reg, out_beat_next;

    logic             advance;
    logic             fire;
    logic             cur_bit;
    logic             fend;
    logic             last;
    logic             idx_done;

    assign pair_valid = out_valid_reg;
    assign pair_data  = out_beat_reg;

    always_comb
    begin
        advance  = !out_valid_reg || !pair_stall;
        fire     = advance && !q_status.empty;
        idx_done = (idx_reg == IDX_W'(PAD_BITS - 1));

        phase_next = phase_reg;
        idx_next   = idx_reg;
        cur_bit    = 1'b0;
        fend       = 1'b0;
        last       = 1'b0;
        pop        = 1'b0;

        unique case (phase_reg)
            PH_DATA:
            begin
                cur_bit = head.data_bit;
                last    = !head.closes;
                if (fire)
                begin
                    pop = !head.closes;
                    if (head.closes)
                    begin
                        phase_next = head.pad ? PH_PAD : PH_CRC;
                    end
                end
            end
            PH_PAD:
            begin
                if (fire)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_done)
                    begin
                        phase_next = PH_CRC;
                    end
                end
            end
            PH_CRC:
            begin
                // crc goes out msb first
                cur_bit = head.crc[~idx_reg];
                fend    = idx_done;
                last    = idx_done;
                if (fire)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_done)
                    begin
                        pop        = 1'b1;
                        phase_next = PH_DATA;
                    end
                end
            end
            default:
            begin
                phase_next = PH_DATA;
            end
        endcase

        hist_next = hist_reg;
        if (fire)
        begin
            // encoder history clears at each frame boundary
            hist_next = fend ? 2'b00 : {hist_reg[0], cur_bit};
        end

        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (advance)
        begin
            out_valid_next = fire;
            out_beat_next.coded_first  = cur_bit ^ hist_reg[0] ^ hist_reg[1];
            out_beat_next.coded_second = cur_bit ^ hist_reg[1];
            out_beat_next.frame_end    = fend;
            out_beat_next.run_last     = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DATA;
            idx_reg       <= '0;
            hist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            hist_reg      <= hist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

`include "frame_crc_conv_encoder_assert.svh"

    `FCCE_ASSERT_SAME(a_frame_end_is_last, clk, rst_n,
        out_valid_reg && out_beat_reg.frame_end, out_beat_reg.run_last)
    `FCCE_ASSERT_SAME(a_pad_needs_short_frame, clk, rst_n,
        phase_reg == PH_PAD, !q_status.empty && head.pad && head.closes)
    `FCCE_ASSERT_SAME(a_crc_needs_close, clk, rst_n,
        phase_reg == PH_CRC, !q_status.empty && head.closes)
    `FCCE_ASSERT_NEXT(a_frame_restart, clk, rst_n,
        fire && phase_reg == PH_CRC && idx_done,
        hist_reg == 2'b00 && phase_reg == PH_DATA && idx_reg == '0)

endmodule

`default_nettype wire

@@ rtl/core/frame_crc_conv_encoder.sv @@
// ---------------------------------------------------------------------------
// frame_crc_conv_encoder
// framing, crc-8 and rate-1/2 k=3 convolutional encoder with apb config
// ---------------------------------------------------------------------------
// Takes one message bit per beat and returns one coded pair per frame bit.
// A bit that fills a frame adds 8 crc pairs and a message_end bit that
// leaves the frame short adds 8 pad and 8 crc pairs; the back end emits one
// pair per cycle while pair_stall is low, and a four-entry queue lets the
// input run on during those bursts until it fills. The crc of the pad bits
// is folded into the close beat at the front, so input never waits for crc
// work. Input beats are registered in the queue, and pairs in the output
// register of the back end. The polynomial register sits at byte address 0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_crc_conv_encoder #(
    parameter int FRAME_PAYLOAD = fcce_pkg::FRAME_PAYLOAD_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fcce_pkg::PADDR_W-1:0] paddr,
    input  wire logic [fcce_pkg::PDATA_W-1:0] pwdata,
    output logic [fcce_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  wire logic                         bit_valid,
    output logic                              bit_stall,
    input  wire fcce_pkg::in_beat_t           bit_data,
    output logic                              pair_valid,
    input  wire logic                         pair_stall,
    output fcce_pkg::out_beat_t               pair_data
);
    import fcce_pkg::*;

    logic [CRC_W-1:0] poly_reg, poly_next;
    logic             poly_sel;
    logic             push;
    job_t             push_job;
    logic             pop;
    job_t             head;
    queue_status_t    q_status;

    assign pready   = 1'b1;
    assign poly_sel = (paddr[PADDR_W-1:2] == REG_CRC_POLY);

    always_comb
    begin
        poly_next = poly_reg;
        if (psel && penable && pwrite && pready && poly_sel)
        begin
            poly_next = pwdata[CRC_W-1:0];
        end
        prdata = poly_sel ? {{(PDATA_W-CRC_W){1'b0}}, poly_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= CRC_POLY_RESET;
        end
        else
        begin
            poly_reg <= poly_next;
        end
    end

    fcce_front #(
        .FRAME_PAYLOAD (FRAME_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .crc_poly  (poly_reg),
        .bit_valid (bit_valid),
        .bit_stall (bit_stall),
        .bit_data  (bit_data),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    fcce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    fcce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair_data  (pair_data)
    );

endmodule

`default_nettype wire
